/* rtl/mtp_pkg.sv */
// ----------------------------------------------------------------------------
// Musical transport position - shared package
// Field widths, command and register codes, serial-unit sizing and the
// control structs passed between the transport sequencer and its units.
// ----------------------------------------------------------------------------
package mtp_pkg;

   // Field widths
   localparam int MODE_W  = 3;
   localparam int COUNT_W = 16;
   localparam int SAMP_W  = 48;
   localparam int SEC_W   = 52;
   localparam int BAR_W   = 40;
   localparam int BEAT_W  = 5;
   localparam int TICK_W  = 10;
   localparam int FRAC_W  = 16;

   // Configuration register widths and reset values
   localparam int BPM_W  = 18;
   localparam int BPB_W  = 5;
   localparam int RATE_W = 19;

   localparam logic [BPM_W-1:0]  BPM_RESET  = 18'd30720;
   localparam logic [BPB_W-1:0]  BPB_RESET  = 5'd4;
   localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;

   // Register bus
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_BPM  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BPB  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RATE = 2'd2;

   // Musical time base
   localparam int TICKS_PER_BEAT = 960;
   localparam int TPB_W          = 12;     // holds ticks per beat up to 4095
   localparam int TICK_SCALE     = 15360;  // 60 s/min * 256 (BPM fraction)
   localparam int TICK_SCALE_W   = 14;

   // Shift-add multiplier sizing
   localparam int MCAND_W  = BPM_W + TPB_W;
   localparam int MPLIER_W = SEC_W;
   localparam int PROD_W   = MPLIER_W + MCAND_W;
   localparam int MCNT_W   = $clog2(MPLIER_W + 1);

   // Restoring divider sizing
   localparam int NUM_W  = PROD_W;
   localparam int DIVR_W = RATE_W + TICK_SCALE_W;
   localparam int QUOT_W = 64;
   localparam int DCNT_W = $clog2(NUM_W + 1);

   localparam int NUM_PAD_SEC = NUM_W - SAMP_W - FRAC_W;
   localparam int NUM_PAD_Q   = NUM_W - QUOT_W;

   localparam logic [MCNT_W-1:0]  MCNT_FULL = MCNT_W'(MPLIER_W);
   localparam logic [DCNT_W-1:0]  DCNT_SEC  = DCNT_W'(SAMP_W + FRAC_W);
   localparam logic [DCNT_W-1:0]  DCNT_TICK = DCNT_W'(NUM_W);
   localparam logic [DCNT_W-1:0]  DCNT_QUOT = DCNT_W'(QUOT_W);

   localparam logic [MCAND_W-1:0] TPB_MCAND        = MCAND_W'(TICKS_PER_BEAT);
   localparam logic [DIVR_W-1:0]  TPB_DIVR         = DIVR_W'(TICKS_PER_BEAT);
   localparam logic [DIVR_W-1:0]  TICK_SCALE_DIVR  = DIVR_W'(TICK_SCALE);

   // Commands
   typedef enum logic [MODE_W-1:0] {
      MODE_ADVANCE     = 3'd0,
      MODE_PLAY        = 3'd1,
      MODE_STOP        = 3'd2,
      MODE_PAUSE       = 3'd3,
      MODE_RECORD      = 3'd4,
      MODE_LOC_SAMPLES = 3'd5,
      MODE_LOC_SECONDS = 3'd6,
      MODE_LOC_BARS    = 3'd7
   } mode_type;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [BPM_W-1:0]  bpm_q8;
      logic [BPB_W-1:0]  beats_per_bar;
      logic [RATE_W-1:0] sample_rate;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [MPLIER_W-1:0] mplier;
      logic [MCAND_W-1:0]  mcand;
   } mul_cmd_type;

   typedef struct packed {
      logic              busy;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DCNT_W-1:0] nbits;
      logic [NUM_W-1:0]  numer;
      logic [DIVR_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
      logic [DIVR_W-1:0] rem;
   } div_rsp_type;

endpackage

/* rtl/mtp_req_if.sv */
// ----------------------------------------------------------------------------
// Musical transport position - command channel
// Valid/ready channel carrying one transport command word.
// ----------------------------------------------------------------------------
interface mtp_req_if;
   logic                              valid;
   logic                              ready;
   logic [mtp_pkg::MODE_W-1:0]        mode;
   logic [mtp_pkg::COUNT_W-1:0]       sample_count;
   logic [mtp_pkg::SAMP_W-1:0]        locate_samples;
   logic [mtp_pkg::SEC_W-1:0]         locate_seconds_q16;
   logic [mtp_pkg::BAR_W-1:0]         locate_bar;
   logic [mtp_pkg::BEAT_W-1:0]        locate_beat;

   modport source (
      output valid, mode, sample_count, locate_samples, locate_seconds_q16,
             locate_bar, locate_beat,
      input  ready
   );

   modport sink (
      input  valid, mode, sample_count, locate_samples, locate_seconds_q16,
             locate_bar, locate_beat,
      output ready
   );
endinterface

/* rtl/mtp_rsp_if.sv */
// ----------------------------------------------------------------------------
// Musical transport position - result channel
// Valid/ready channel carrying the transport flags and position word.
// ----------------------------------------------------------------------------
interface mtp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_playing;
   logic                          is_recording;
   logic [mtp_pkg::SAMP_W-1:0]    position_samples;
   logic [mtp_pkg::SEC_W-1:0]     position_seconds_q16;
   logic [mtp_pkg::BAR_W-1:0]     bar_number;
   logic [mtp_pkg::BEAT_W-1:0]    beat_number;
   logic [mtp_pkg::TICK_W-1:0]    tick_number;
   logic                          status;

   modport source (
      output valid, is_playing, is_recording, position_samples,
             position_seconds_q16, bar_number, beat_number, tick_number, status,
      input  ready
   );

   modport sink (
      input  valid, is_playing, is_recording, position_samples,
             position_seconds_q16, bar_number, beat_number, tick_number, status,
      output ready
   );
endinterface

/* rtl/mtp_csr.sv */
// ----------------------------------------------------------------------------
// Musical transport position - configuration registers
// APB-style register file for tempo, time signature and sample rate.
// ----------------------------------------------------------------------------
module mtp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mtp_pkg::ADDR_W-1:0]    paddr,
   input  logic [mtp_pkg::DATA_W-1:0]    pwdata,
   output logic [mtp_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output mtp_pkg::cfg_type              cfg
);

   logic [mtp_pkg::BPM_W-1:0]     bpm_ff, bpm_in;
   logic [mtp_pkg::BPB_W-1:0]     bpb_ff, bpb_in;
   logic [mtp_pkg::RATE_W-1:0]    rate_ff, rate_in;
   logic                          wr_en;
   logic [mtp_pkg::REG_IDX_W-1:0] reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[mtp_pkg::ADDR_W-1:2];
   assign pready  = 1'b1;

   always_comb begin
      bpm_in  = bpm_ff;
      bpb_in  = bpb_ff;
      rate_in = rate_ff;
      if (wr_en) begin
         case (reg_idx)
            mtp_pkg::REG_BPM:  bpm_in  = pwdata[mtp_pkg::BPM_W-1:0];
            mtp_pkg::REG_BPB:  bpb_in  = pwdata[mtp_pkg::BPB_W-1:0];
            mtp_pkg::REG_RATE: rate_in = pwdata[mtp_pkg::RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mtp_pkg::REG_BPM:  prdata = (mtp_pkg::DATA_W)'(bpm_ff);
         mtp_pkg::REG_BPB:  prdata = (mtp_pkg::DATA_W)'(bpb_ff);
         mtp_pkg::REG_RATE: prdata = (mtp_pkg::DATA_W)'(rate_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpm_ff  <= mtp_pkg::BPM_RESET;
         bpb_ff  <= mtp_pkg::BPB_RESET;
         rate_ff <= mtp_pkg::RATE_RESET;
      end else begin
         bpm_ff  <= bpm_in;
         bpb_ff  <= bpb_in;
         rate_ff <= rate_in;
      end
   end

   assign cfg.bpm_q8        = bpm_ff;
   assign cfg.beats_per_bar = bpb_ff;
   assign cfg.sample_rate   = rate_ff;

endmodule

/* rtl/mtp_mul.sv */
// ----------------------------------------------------------------------------
// Musical transport position - bit-serial multiplier
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module mtp_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  mtp_pkg::mul_cmd_type  cmd,
   output mtp_pkg::mul_rsp_type  rsp
);

   logic                            busy_ff, busy_in;
   logic [mtp_pkg::MCNT_W-1:0]      cnt_ff, cnt_in;
   logic [mtp_pkg::MPLIER_W-1:0]    mplier_ff, mplier_in;
   logic [mtp_pkg::MCAND_W-1:0]     mcand_ff, mcand_in;
   logic [mtp_pkg::MCAND_W-1:0]     acc_ff, acc_in;
   logic [mtp_pkg::MCAND_W:0]       sum;

   // Partial sum for the current multiplier bit
   assign sum = {1'b0, acc_ff} + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         cnt_in    = mtp_pkg::MCNT_FULL;
         mplier_in = cmd.mplier;
         mcand_in  = cmd.mcand;
         acc_in    = '0;
      end else if (busy_ff) begin
         // Shift the accumulator and multiplier right as one word
         acc_in    = sum[mtp_pkg::MCAND_W:1];
         mplier_in = {sum[0], mplier_ff[mtp_pkg::MPLIER_W-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         busy_in   = (cnt_ff != (mtp_pkg::MCNT_W)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.prod = {acc_ff, mplier_ff};

endmodule

/* rtl/mtp_div.sv */
// ----------------------------------------------------------------------------
// Musical transport position - bit-serial divider
// Restoring divider, one numerator bit per cycle MSB first, with remainder
// and a sticky flag for quotient bits beyond the kept width.
// ----------------------------------------------------------------------------
module mtp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  mtp_pkg::div_cmd_type  cmd,
   output mtp_pkg::div_rsp_type  rsp
);

   logic                          busy_ff, busy_in;
   logic [mtp_pkg::DCNT_W-1:0]    cnt_ff, cnt_in;
   logic [mtp_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [mtp_pkg::DIVR_W-1:0]    divr_ff, divr_in;
   logic [mtp_pkg::DIVR_W-1:0]    rem_ff, rem_in;
   logic [mtp_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic                          ovf_ff, ovf_in;
   logic [mtp_pkg::DIVR_W+1:0]    diff;
   logic                          fits;

   // Trial subtract of the divisor from the shifted partial remainder
   assign diff = {1'b0, rem_ff, num_ff[mtp_pkg::NUM_W-1]} - {2'b00, divr_ff};
   assign fits = !diff[mtp_pkg::DIVR_W+1];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      divr_in = divr_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.nbits;
         num_in  = cmd.numer;
         divr_in = cmd.divisor;
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[mtp_pkg::DIVR_W-1:0]
                        : {rem_ff[mtp_pkg::DIVR_W-2:0], num_ff[mtp_pkg::NUM_W-1]};
         quot_in = {quot_ff[mtp_pkg::QUOT_W-2:0], fits};
         ovf_in  = ovf_ff | quot_ff[mtp_pkg::QUOT_W-1];
         num_in  = {num_ff[mtp_pkg::NUM_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != (mtp_pkg::DCNT_W)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      divr_ff <= divr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* rtl/musical_transport_position_core.sv */
// ----------------------------------------------------------------------------
// Musical transport position - top level
// Transport clock: run flags, sample position, time in seconds and
// bar/beat/tick, driven by one command word at a time.
// ----------------------------------------------------------------------------
// One command word is taken at a time and each produces exactly one result
// word. Play, pause, record, stop, locate samples, locate bars and advance
// while not playing go straight to the publishing state. Locate seconds waits
// on the 52-bit serial multiply of the time by the sample rate. Advance while
// playing runs the bit-serial divider four times in a row (seconds, 64
// bits; total ticks, 82 bits; beats, 64 bits; bars, 64 bits), and the tick
// product from the bit-serial multiplier is built in parallel with the first
// of them. A new command word is taken as soon as the sequencer is idle, even
// while the previous result word still waits in the output register. Reset is
// synchronous and needs no clearing time. Register writes are expected only
// while no command is in flight.
module musical_transport_position_core (
   input  logic                          clock,
   input  logic                          reset,
   mtp_req_if.sink                       req_ch,
   mtp_rsp_if.source                     rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mtp_pkg::ADDR_W-1:0]    paddr,
   input  logic [mtp_pkg::DATA_W-1:0]    pwdata,
   output logic [mtp_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEC,
      ST_TICK,
      ST_BEAT,
      ST_BAR,
      ST_LOC,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                          is_playing;
      logic                          is_recording;
      logic [mtp_pkg::SAMP_W-1:0]    position_samples;
      logic [mtp_pkg::SEC_W-1:0]     position_seconds_q16;
      logic [mtp_pkg::BAR_W-1:0]     bar_number;
      logic [mtp_pkg::BEAT_W-1:0]    beat_number;
      logic [mtp_pkg::TICK_W-1:0]    tick_number;
      logic                          status;
   } rsp_word_type;

   mtp_pkg::cfg_type      cfg;
   mtp_pkg::mul_cmd_type  mul_cmd;
   mtp_pkg::mul_rsp_type  mul_rsp;
   mtp_pkg::div_cmd_type  div_cmd;
   mtp_pkg::div_rsp_type  div_rsp;

   state_type                     state_ff, state_in;
   logic                          playing_ff, playing_in;
   logic                          recording_ff, recording_in;
   logic [mtp_pkg::SAMP_W-1:0]    samp_ff, samp_in;
   logic [mtp_pkg::SEC_W-1:0]     sec_ff, sec_in;
   logic [mtp_pkg::BAR_W-1:0]     bar_ff, bar_in;
   logic [mtp_pkg::BEAT_W-1:0]    beat_ff, beat_in;
   logic [mtp_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic                          status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_word_type                  rsp_word_ff, rsp_word_in;

   logic [mtp_pkg::SAMP_W:0]      samp_sum;
   logic [mtp_pkg::SAMP_W-1:0]    samp_adv;
   logic [mtp_pkg::RATE_W-1:0]    rate_nz;
   logic [mtp_pkg::BPB_W-1:0]     bpb_nz;
   logic [mtp_pkg::MCAND_W-1:0]   mcand_adv;
   logic [mtp_pkg::DIVR_W-1:0]    tick_divr;
   logic [mtp_pkg::QUOT_W-1:0]    ticks;
   logic                          sec_sat;
   logic                          bar_sat;
   logic                          loc_sat;
   logic                          bad_locate;

   mtp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mtp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   mtp_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // Advance: add the block length, clamp at the top of the 48-bit range
   assign samp_sum = {1'b0, samp_ff} + (mtp_pkg::SAMP_W+1)'(req_ch.sample_count);
   assign samp_adv = samp_sum[mtp_pkg::SAMP_W] ? '1 : samp_sum[mtp_pkg::SAMP_W-1:0];

   // In advance, a zero rate or zero bar length converts as if it were one
   assign rate_nz = (cfg.sample_rate == '0) ? (mtp_pkg::RATE_W)'(1) : cfg.sample_rate;
   assign bpb_nz  = (cfg.beats_per_bar == '0) ? (mtp_pkg::BPB_W)'(1) : cfg.beats_per_bar;

   // Ticks = samples * bpm_q8 * ticks_per_beat / (15360 * rate)
   assign mcand_adv = (mtp_pkg::MCAND_W)'(cfg.bpm_q8) * mtp_pkg::TPB_MCAND;
   assign tick_divr = (mtp_pkg::DIVR_W)'(rate_nz) * mtp_pkg::TICK_SCALE_DIVR;

   assign ticks   = div_rsp.ovf ? '1 : div_rsp.quot;
   assign sec_sat = div_rsp.ovf || (|div_rsp.quot[mtp_pkg::QUOT_W-1:mtp_pkg::SEC_W]);
   assign bar_sat = (|div_rsp.quot[mtp_pkg::QUOT_W-1:mtp_pkg::BAR_W])
                    || (&div_rsp.quot[mtp_pkg::BAR_W-1:0]);
   // Locate seconds: samples = product >> 16, clamped when bits 64 and up are set
   assign loc_sat = |mul_rsp.prod[mtp_pkg::PROD_W-1:mtp_pkg::QUOT_W];

   assign bad_locate = (req_ch.locate_bar == '0) || (req_ch.locate_beat == '0)
                       || (req_ch.locate_beat > cfg.beats_per_bar);

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      playing_in   = playing_ff;
      recording_in = recording_ff;
      samp_in      = samp_ff;
      sec_in       = sec_ff;
      bar_in       = bar_ff;
      beat_in      = beat_ff;
      tick_in      = tick_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mul_cmd      = '0;
      div_cmd      = '0;

      // Drop the result word once the sink has taken it
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               status_in = mtp_pkg::STATUS_OK;
               state_in  = ST_FIN;
               case (req_ch.mode)
                  mtp_pkg::MODE_ADVANCE: begin
                     if (playing_ff) begin
                        // Launch the tick product and the seconds division together
                        samp_in         = samp_adv;
                        mul_cmd.start   = 1'b1;
                        mul_cmd.mplier  = (mtp_pkg::MPLIER_W)'(samp_adv);
                        mul_cmd.mcand   = mcand_adv;
                        div_cmd.start   = 1'b1;
                        div_cmd.nbits   = mtp_pkg::DCNT_SEC;
                        div_cmd.numer   = {samp_adv, {mtp_pkg::FRAC_W{1'b0}},
                                           {mtp_pkg::NUM_PAD_SEC{1'b0}}};
                        div_cmd.divisor = (mtp_pkg::DIVR_W)'(rate_nz);
                        state_in        = ST_SEC;
                     end
                  end
                  mtp_pkg::MODE_PLAY: begin
                     playing_in   = 1'b1;
                     recording_in = 1'b0;
                  end
                  mtp_pkg::MODE_STOP: begin
                     playing_in   = 1'b0;
                     recording_in = 1'b0;
                     samp_in      = '0;
                     sec_in       = '0;
                     bar_in       = (mtp_pkg::BAR_W)'(1);
                     beat_in      = (mtp_pkg::BEAT_W)'(1);
                     tick_in      = '0;
                  end
                  mtp_pkg::MODE_PAUSE: begin
                     playing_in = 1'b0;
                  end
                  mtp_pkg::MODE_RECORD: begin
                     playing_in   = 1'b1;
                     recording_in = 1'b1;
                  end
                  mtp_pkg::MODE_LOC_SAMPLES: begin
                     samp_in = req_ch.locate_samples;
                  end
                  mtp_pkg::MODE_LOC_SECONDS: begin
                     sec_in         = req_ch.locate_seconds_q16;
                     mul_cmd.start  = 1'b1;
                     mul_cmd.mplier = req_ch.locate_seconds_q16;
                     mul_cmd.mcand  = (mtp_pkg::MCAND_W)'(cfg.sample_rate);
                     state_in       = ST_LOC;
                  end
                  mtp_pkg::MODE_LOC_BARS: begin
                     // Reject leaves the position alone
                     if (bad_locate) begin
                        status_in = mtp_pkg::STATUS_REJECT;
                     end else begin
                        bar_in  = req_ch.locate_bar;
                        beat_in = req_ch.locate_beat;
                        tick_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SEC: begin
            if (!mul_rsp.busy && !div_rsp.busy) begin
               sec_in          = sec_sat ? '1 : div_rsp.quot[mtp_pkg::SEC_W-1:0];
               div_cmd.start   = 1'b1;
               div_cmd.nbits   = mtp_pkg::DCNT_TICK;
               div_cmd.numer   = mul_rsp.prod;
               div_cmd.divisor = tick_divr;
               state_in        = ST_TICK;
            end
         end

         ST_TICK: begin
            // Split total ticks into beats and the tick within the beat
            if (!div_rsp.busy) begin
               div_cmd.start   = 1'b1;
               div_cmd.nbits   = mtp_pkg::DCNT_QUOT;
               div_cmd.numer   = {ticks, {mtp_pkg::NUM_PAD_Q{1'b0}}};
               div_cmd.divisor = mtp_pkg::TPB_DIVR;
               state_in        = ST_BEAT;
            end
         end

         ST_BEAT: begin
            // Split beats into bars and the beat within the bar
            if (!div_rsp.busy) begin
               tick_in         = div_rsp.rem[mtp_pkg::TICK_W-1:0];
               div_cmd.start   = 1'b1;
               div_cmd.nbits   = mtp_pkg::DCNT_QUOT;
               div_cmd.numer   = {div_rsp.quot, {mtp_pkg::NUM_PAD_Q{1'b0}}};
               div_cmd.divisor = (mtp_pkg::DIVR_W)'(bpb_nz);
               state_in        = ST_BAR;
            end
         end

         ST_BAR: begin
            if (!div_rsp.busy) begin
               bar_in   = bar_sat ? '1
                                  : div_rsp.quot[mtp_pkg::BAR_W-1:0] + (mtp_pkg::BAR_W)'(1);
               beat_in  = div_rsp.rem[mtp_pkg::BEAT_W-1:0] + (mtp_pkg::BEAT_W)'(1);
               state_in = ST_FIN;
            end
         end

         ST_LOC: begin
            if (!mul_rsp.busy) begin
               samp_in  = loc_sat ? '1
                                  : mul_rsp.prod[mtp_pkg::QUOT_W-1:mtp_pkg::FRAC_W];
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            // Hold until the output register is free, then publish the state
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in                     = 1'b1;
               rsp_word_in.is_playing           = playing_ff;
               rsp_word_in.is_recording         = recording_ff;
               rsp_word_in.position_samples     = samp_ff;
               rsp_word_in.position_seconds_q16 = sec_ff;
               rsp_word_in.bar_number           = bar_ff;
               rsp_word_in.beat_number          = beat_ff;
               rsp_word_in.tick_number          = tick_ff;
               rsp_word_in.status               = status_ff;
               state_in                         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         playing_ff   <= 1'b0;
         recording_ff <= 1'b0;
         samp_ff      <= '0;
         sec_ff       <= '0;
         bar_ff       <= (mtp_pkg::BAR_W)'(1);
         beat_ff      <= (mtp_pkg::BEAT_W)'(1);
         tick_ff      <= '0;
         status_ff    <= mtp_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         recording_ff <= recording_in;
         samp_ff      <= samp_in;
         sec_ff       <= sec_in;
         bar_ff       <= bar_in;
         beat_ff      <= beat_in;
         tick_ff      <= tick_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.is_playing           = rsp_word_ff.is_playing;
   assign rsp_ch.is_recording         = rsp_word_ff.is_recording;
   assign rsp_ch.position_samples     = rsp_word_ff.position_samples;
   assign rsp_ch.position_seconds_q16 = rsp_word_ff.position_seconds_q16;
   assign rsp_ch.bar_number           = rsp_word_ff.bar_number;
   assign rsp_ch.beat_number          = rsp_word_ff.beat_number;
   assign rsp_ch.tick_number          = rsp_word_ff.tick_number;
   assign rsp_ch.status               = rsp_word_ff.status;

endmodule
